// ===== design/pcse_pkg.sv =====
// ----------------------------------------------------------------------------
// pcse_pkg
// Shared types, constants and saturation helper for the piecewise cubic
// spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcse_pkg;

  // Default sizing
  localparam int MAX_KNOTS_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 9;
  localparam int IDX_W  = 8;
  localparam int WIDE_W = 66;

  // Reset value of the knot count register
  localparam logic [CFG_W-1:0] KNOTS_RESET = CFG_W'(2);

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_e;

  // Clipped value and its clip flag
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } sat_res_t;

  // Clip a wide signed value to the 32-bit signed range
  function automatic sat_res_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_res_t r;
    localparam logic signed [WIDE_W-1:0] VMAX = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [WIDE_W-1:0] VMIN = WIDE_W'(-64'sh0000_0000_8000_0000);
    if (v > VMAX) begin
      r.val = 32'sh7FFF_FFFF;
      r.sat = 1'b1;
    end else if (v < VMIN) begin
      r.val = 32'sh8000_0000;
      r.sat = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/pcse_ram.sv =====
// ----------------------------------------------------------------------------
// pcse_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pcse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/pcse_mac.sv =====
// ----------------------------------------------------------------------------
// pcse_mac
// Shared Horner step unit: registered 32x32 product, then round half up,
// add coefficient and saturate to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pcse_mac #(
  parameter int FRAC_BITS = pcse_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                mul_en_i,
  input  wire logic signed [pcse_pkg::DATA_W-1:0]  mul_a_i,
  input  wire logic signed [pcse_pkg::DATA_W-1:0]  mul_b_i,
  input  wire logic signed [pcse_pkg::DATA_W-1:0]  coef_i,
  output pcse_pkg::sat_res_t                       res_o
);

  import pcse_pkg::*;

  localparam int PW = 2 * DATA_W;
  localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FRAC_BITS - 1));

  logic signed [PW-1:0]     prod_q;
  logic signed [PW-1:0]     rnd;
  logic signed [PW-1:0]     shr;
  logic signed [WIDE_W-1:0] sum;

  // Product register
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= mul_a_i * mul_b_i;
    end
  end

  // Round half up, floor shift, add and clip
  assign rnd   = prod_q + HALF;
  assign shr   = rnd >>> FRAC_BITS;
  assign sum   = WIDE_W'(coef_i) + WIDE_W'(shr);
  assign res_o = sat32(sum);

endmodule

`default_nettype wire

// ===== design/piecewise_cubic_spline_eval.sv =====
// ----------------------------------------------------------------------------
// piecewise_cubic_spline_eval
// Piecewise cubic evaluator over a loadable knot and coefficient table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): a load item (req_type 0) writes
//   one knot position and the four coefficients of the interval starting at
//   knot_index and yields no result. An evaluate item (req_type 1) scans
//   intervals in order for the first upper knot at or above query_x, then
//   runs three Horner steps on one shared multiply/add unit.
//   Config channel (cfg_valid_i/cfg_ready_o) sets knots_in_use and is always
//   ready; the user must have it written only while the block is idle, as
//   the block itself does not enforce it. An evaluate does one knot compare
//   per cycle from the knot RAM read port, then fetch and load, a multiply
//   and an add on the shared multiplier unit per Horner step, and emit.
//   in_ready_o is low while an evaluate is in progress; loads go one per
//   cycle while the block is idle.
//   Output channel (out_valid_o/out_ready_i): one result per evaluate item,
//   held in an output register; a next item may be accepted while it waits.
//   If the receiver stalls, a finished result waits in the sequencer until
//   the output register frees up.
//   Reset: knots_in_use returns to 2, output empty; table contents are not
//   cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_cubic_spline_eval #(
  parameter int MAX_KNOTS = pcse_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = pcse_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config write
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pcse_pkg::CFG_W-1:0]         cfg_data_i,
  // input items
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               req_type_i,
  input  wire logic [pcse_pkg::IDX_W-1:0]         knot_index_i,
  input  wire logic signed [pcse_pkg::DATA_W-1:0] knot_pos_i,
  input  wire logic signed [pcse_pkg::DATA_W-1:0] coef_const_i,
  input  wire logic signed [pcse_pkg::DATA_W-1:0] coef_lin_i,
  input  wire logic signed [pcse_pkg::DATA_W-1:0] coef_quad_i,
  input  wire logic signed [pcse_pkg::DATA_W-1:0] coef_cube_i,
  input  wire logic signed [pcse_pkg::DATA_W-1:0] query_x_i,
  // result items
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [pcse_pkg::DATA_W-1:0]      spline_value_o,
  output logic                                    found_o,
  output logic                                    saturated_o
);

  import pcse_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MAXK = CW'(MAX_KNOTS);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CFG_W-1:0]  knots_q, knots_d;
  logic              out_valid_q, out_valid_d;

  logic [CW-1:0]     scan_q, scan_d;     // next knot address to read
  logic              pend_q, pend_d;     // a knot read is in flight
  logic [AW-1:0]     pk_q, pk_d;         // interval of the read in flight
  logic [AW-1:0]     k_q, k_d;           // selected interval
  logic [CW-1:0]     n_q, n_d;           // clamped knot count
  logic [1:0]        step_q, step_d;     // Horner step 0..2

  logic signed [DATA_W-1:0] x_q, x_d;
  logic signed [DATA_W-1:0] dx_q, dx_d;
  logic signed [DATA_W-1:0] s_q, s_d;
  logic                     sat_q, sat_d;
  logic                     found_q, found_d;
  logic signed [DATA_W-1:0] c0_q, c0_d, c1_q, c1_d, c2_q, c2_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     fnd_q, fnd_d;
  logic                     osat_q, osat_d;

  // --------------------------------------------------------------------------
  // Table memories
  // --------------------------------------------------------------------------
  logic              tbl_we;
  logic [31:0]       idx_ext;
  logic [AW-1:0]     tbl_waddr;
  logic [AW-1:0]     knot_raddr;
  logic [AW-1:0]     coef_raddr;
  logic [DATA_W-1:0] knot_rd, const_rd, lin_rd, quad_rd, cube_rd;

  assign idx_ext   = 32'(knot_index_i);
  assign tbl_waddr = idx_ext[AW-1:0];
  assign tbl_we    = in_valid_i && in_ready_o && (req_type_i == REQ_LOAD)
                     && (idx_ext < 32'(MAX_KNOTS));
  assign coef_raddr = k_q;

  pcse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS), .AW(AW)) u_knot_ram (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(knot_pos_i),
    .raddr_i(knot_raddr), .rdata_o(knot_rd)
  );
  pcse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS), .AW(AW)) u_const_ram (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(coef_const_i),
    .raddr_i(coef_raddr), .rdata_o(const_rd)
  );
  pcse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS), .AW(AW)) u_lin_ram (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(coef_lin_i),
    .raddr_i(coef_raddr), .rdata_o(lin_rd)
  );
  pcse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS), .AW(AW)) u_quad_ram (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(coef_quad_i),
    .raddr_i(coef_raddr), .rdata_o(quad_rd)
  );
  pcse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS), .AW(AW)) u_cube_ram (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(coef_cube_i),
    .raddr_i(coef_raddr), .rdata_o(cube_rd)
  );

  // --------------------------------------------------------------------------
  // Shared Horner unit
  // --------------------------------------------------------------------------
  logic                     mul_en;
  logic signed [DATA_W-1:0] mac_coef;
  sat_res_t                 mac_res;

  always_comb begin
    unique case (step_q)
      2'd0:    mac_coef = c2_q;
      2'd1:    mac_coef = c1_q;
      default: mac_coef = c0_q;
    endcase
  end

  pcse_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i,
    .mul_en_i(mul_en),
    .mul_a_i (dx_q),
    .mul_b_i (s_q),
    .coef_i  (mac_coef),
    .res_o   (mac_res)
  );

  // Offset from the lower knot, clipped
  sat_res_t                 dx_res;
  logic signed [WIDE_W-1:0] dx_wide;
  assign dx_wide = WIDE_W'(x_q) - WIDE_W'($signed(knot_rd));
  assign dx_res  = sat32(dx_wide);

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign spline_value_o = val_q;
  assign found_o        = fnd_q;
  assign saturated_o    = osat_q;

  // --------------------------------------------------------------------------
  // Sequencer: next state and datapath controls
  // --------------------------------------------------------------------------
  always_comb begin
    logic [CW-1:0] knots_ext;
    state_d     = state_q;
    knots_d     = knots_q;
    out_valid_d = out_valid_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pk_d        = pk_q;
    k_d         = k_q;
    n_d         = n_q;
    step_d      = step_q;
    x_d         = x_q;
    dx_d        = dx_q;
    s_d         = s_q;
    sat_d       = sat_q;
    found_d     = found_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    c2_d        = c2_q;
    val_d       = val_q;
    fnd_d       = fnd_q;
    osat_d      = osat_q;
    mul_en      = 1'b0;
    knot_raddr  = scan_q[AW-1:0];
    knots_ext   = (32'(knots_q) > 32'(MAX_KNOTS)) ? MAXK : CW'(knots_q);

    // config write
    if (cfg_valid_i) begin
      knots_d = cfg_data_i;
    end

    // output register drains
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (req_type_i == REQ_EVAL)) begin
          x_d     = query_x_i;
          n_d     = knots_ext;
          scan_d  = CW'(1);
          pend_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end

      // one knot compare per cycle against the read issued last cycle
      ST_SCAN: begin
        if (pend_q && (x_q <= $signed(knot_rd))) begin
          k_d     = pk_q;
          state_d = ST_FETCH;
        end else if (scan_q >= n_q) begin
          s_d     = '0;
          sat_d   = 1'b0;
          found_d = 1'b0;
          state_d = ST_EMIT;
        end else begin
          pend_d = 1'b1;
          pk_d   = AW'(scan_q - CW'(1));
          scan_d = scan_q + CW'(1);
        end
      end

      // read lower knot and coefficients of the chosen interval
      ST_FETCH: begin
        knot_raddr = k_q;
        state_d    = ST_LOAD;
      end

      ST_LOAD: begin
        dx_d    = dx_res.val;
        sat_d   = dx_res.sat;
        s_d     = $signed(cube_rd);
        c0_d    = $signed(const_rd);
        c1_d    = $signed(lin_rd);
        c2_d    = $signed(quad_rd);
        found_d = 1'b1;
        step_d  = 2'd0;
        state_d = ST_MUL;
      end

      ST_MUL: begin
        mul_en  = 1'b1;
        state_d = ST_ADD;
      end

      ST_ADD: begin
        s_d   = mac_res.val;
        sat_d = sat_q | mac_res.sat;
        if (step_q == 2'd2) begin
          state_d = ST_EMIT;
        end else begin
          step_d  = step_q + 2'd1;
          state_d = ST_MUL;
        end
      end

      // hand the result to the output register once it is free
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          val_d       = s_q;
          fnd_d       = found_q;
          osat_d      = sat_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      knots_q     <= KNOTS_RESET;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      scan_q      <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      knots_q     <= knots_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      scan_q      <= scan_d;
      step_q      <= step_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pk_q    <= pk_d;
    k_q     <= k_d;
    n_q     <= n_d;
    x_q     <= x_d;
    dx_q    <= dx_d;
    s_q     <= s_d;
    sat_q   <= sat_d;
    found_q <= found_d;
    c0_q    <= c0_d;
    c1_q    <= c1_d;
    c2_q    <= c2_d;
    val_q   <= val_d;
    fnd_q   <= fnd_d;
    osat_q  <= osat_d;
  end

endmodule

`default_nettype wire

// ===== sim/piecewise_cubic_spline_eval_tb.sv =====
// ----------------------------------------------------------------------------
// piecewise_cubic_spline_eval_tb
// Loads knot/coefficient tables, sweeps the knot count register and checks
// every evaluate result against a cycle-free spline predictor kept in the
// bench. A short directed run hits range limits, clipping and rounding ties;
// random phases follow with ordered tables, boundary-heavy queries, table
// rewrites and stray loads under several sender/receiver idling patterns.
// ----------------------------------------------------------------------------

module piecewise_cubic_spline_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcse_pkg::*;

  localparam int     TBL_DEPTH    = MAX_KNOTS_DEF;
  localparam int     FRAC         = FRAC_BITS_DEF;
  localparam longint Q_HI         = 64'sd2147483647;
  localparam longint Q_LO         = -64'sd2147483648;
  localparam logic signed [DATA_W-1:0] Q_MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN32 = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] ONE_Q   = 32'sh0001_0000;
  localparam int     SETTLE_CYCLES = 300;
  localparam int     HOLD_CYCLES   = 1500;

  typedef struct {
    logic                     req;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
    logic signed [DATA_W-1:0] qx;
  } req_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     found;
    logic                     sat;
  } spline_out_t;

  // DUT hookup
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     req_type = REQ_LOAD;
  logic [IDX_W-1:0]         knot_index = '0;
  logic signed [DATA_W-1:0] knot_pos = '0;
  logic signed [DATA_W-1:0] coef_const = '0;
  logic signed [DATA_W-1:0] coef_lin = '0;
  logic signed [DATA_W-1:0] coef_quad = '0;
  logic signed [DATA_W-1:0] coef_cube = '0;
  logic signed [DATA_W-1:0] query_x = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] spline_value;
  logic                     found;
  logic                     saturated;

  // Predictor state
  logic signed [DATA_W-1:0] knot_tbl [TBL_DEPTH];
  logic signed [DATA_W-1:0] a_tbl [TBL_DEPTH];
  logic signed [DATA_W-1:0] b_tbl [TBL_DEPTH];
  logic signed [DATA_W-1:0] c_tbl [TBL_DEPTH];
  logic signed [DATA_W-1:0] d_tbl [TBL_DEPTH];
  logic [CFG_W-1:0]         knots_cfg = KNOTS_RESET;

  // Stimulus side: what the pending loads will leave in the table
  logic signed [DATA_W-1:0] gen_pos [TBL_DEPTH];
  bit                       gen_loaded [TBL_DEPTH];

  req_item_t   req_q[$];
  spline_out_t spline_q[$];

  int n_pushed = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic in_acc = 1'b0;

  piecewise_cubic_spline_eval dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .knot_index_i   (knot_index),
    .knot_pos_i     (knot_pos),
    .coef_const_i   (coef_const),
    .coef_lin_i     (coef_lin),
    .coef_quad_i    (coef_quad),
    .coef_cube_i    (coef_cube),
    .query_x_i      (query_x),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .spline_value_o (spline_value),
    .found_o        (found),
    .saturated_o    (saturated)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [DATA_W-1:0] clip_q(input longint v, inout logic clipped);
    if (v > Q_HI) begin
      clipped = 1'b1;
      return Q_MAX32;
    end
    if (v < Q_LO) begin
      clipped = 1'b1;
      return Q_MIN32;
    end
    return v[DATA_W-1:0];
  endfunction

  // coef + round_half_up(dx * s), clipped
  function automatic logic signed [DATA_W-1:0] horner_step(input longint coef, input longint dx,
                                                           input longint s, inout logic clipped);
    longint half;
    half = longint'(1) << (FRAC - 1);
    return clip_q(coef + ((dx * s + half) >>> FRAC), clipped);
  endfunction

  function automatic spline_out_t spline_at(input logic signed [DATA_W-1:0] qx);
    spline_out_t r;
    int          n;
    int          k;
    bit          hit;
    logic        clipped;
    longint      dx;
    longint      s;
    r.value = '0;
    r.found = 1'b0;
    r.sat   = 1'b0;
    clipped = 1'b0;
    hit     = 1'b0;
    k       = 0;
    n = (int'(knots_cfg) > TBL_DEPTH) ? TBL_DEPTH : int'(knots_cfg);
    // first interval whose upper knot is at or above the query
    for (int i = 0; i + 1 < n && !hit; i++) begin
      if (longint'(qx) <= longint'(knot_tbl[i+1])) begin
        hit = 1'b1;
        k   = i;
      end
    end
    if (!hit) return r;
    dx = clip_q(longint'(qx) - longint'(knot_tbl[k]), clipped);
    s  = d_tbl[k];
    s  = horner_step(c_tbl[k], dx, s, clipped);
    s  = horner_step(b_tbl[k], dx, s, clipped);
    s  = horner_step(a_tbl[k], dx, s, clipped);
    r.value = s[DATA_W-1:0];
    r.found = 1'b1;
    r.sat   = clipped;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [DATA_W-1:0] fit_q(input longint v);
    logic dummy;
    dummy = 1'b0;
    return clip_q(v, dummy);
  endfunction

  // uniform in [-half, half], half below 2^31
  function automatic longint rand_span(input longint half);
    return longint'($urandom_range(32'(2 * half))) - half;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_coef(input int sh);
    case ($urandom_range(19))
      0:       return $urandom;
      1:       return Q_MAX32;
      2:       return Q_MIN32;
      default: return fit_q(rand_span(longint'(1) << sh));
    endcase
  endfunction

  function automatic void mk_load(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] pos,
                                  input logic signed [DATA_W-1:0] a,
                                  input logic signed [DATA_W-1:0] b,
                                  input logic signed [DATA_W-1:0] c,
                                  input logic signed [DATA_W-1:0] d);
    req_item_t it;
    it.req = REQ_LOAD;
    it.idx = idx;
    it.pos = pos;
    it.a   = a;
    it.b   = b;
    it.c   = c;
    it.d   = d;
    it.qx  = $urandom;
    gen_pos[idx]    = pos;
    gen_loaded[idx] = 1'b1;
    req_q.push_back(it);
    n_pushed++;
  endfunction

  // unused fields carry junk; the block must ignore them
  function automatic void mk_eval(input logic signed [DATA_W-1:0] qx);
    req_item_t it;
    it.req = REQ_EVAL;
    it.idx = IDX_W'($urandom);
    it.pos = $urandom;
    it.a   = $urandom;
    it.b   = $urandom;
    it.c   = $urandom;
    it.d   = $urandom;
    it.qx  = qx;
    req_q.push_back(it);
    n_pushed++;
  endfunction

  // ordered knots, occasional duplicates when the step comes out zero
  function automatic void build_table(input int m);
    longint base;
    longint step;
    step = ($urandom_range(3) == 0) ? longint'($urandom_range(16))
                                    : longint'($urandom_range(1, 1 << 20));
    base = rand_span(longint'(1) << 30);
    for (int i = 0; i < m; i++) begin
      mk_load(IDX_W'(i), fit_q(base + i * step), rand_coef(24), rand_coef(20),
              rand_coef(18), rand_coef(16));
    end
  endfunction

  // queries cluster on knots, just off them, and past both table ends
  function automatic logic signed [DATA_W-1:0] next_query(input int m);
    int k;
    int last;
    k    = (m > 0) ? $urandom_range(m - 1) : 0;
    last = (m > 0) ? m - 1 : 0;
    case ($urandom_range(9))
      0, 1:    return gen_pos[k];
      2:       return fit_q(longint'(gen_pos[k]) + 1);
      3:       return fit_q(longint'(gen_pos[k]) - 1);
      4, 5, 6: return fit_q(longint'(gen_pos[k]) + rand_span(longint'(1) << 20));
      7:       return fit_q(longint'(gen_pos[last]) + rand_span(longint'(1) << 12));
      8:       return $urandom;
      default: return $urandom_range(1) ? Q_MAX32 : Q_MIN32;
    endcase
  endfunction

  // ---------------------------------------------------------------- channels

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("%0t: MISMATCH %s", $time, msg);
  endtask

  // input driver: next pending item once the current one is taken
  always @(negedge clk) begin : drive_items
    req_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        in_valid   <= 1'b1;
        req_type   <= nxt.req;
        knot_index <= nxt.idx;
        knot_pos   <= nxt.pos;
        coef_const <= nxt.a;
        coef_lin   <= nxt.b;
        coef_quad  <= nxt.c;
        coef_cube  <= nxt.d;
        query_x    <= nxt.qx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: update the predictor on accepted items, check results
  always @(posedge clk) begin : watch
    spline_out_t want;
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        n_results++;
        if (spline_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no evaluate pending", n_results));
        end else begin
          want = spline_q.pop_front();
          if (spline_value !== want.value)
            report_mismatch($sformatf("result %0d: spline_value %0d, expected %0d",
                                      n_results, spline_value, want.value));
          if (found !== want.found)
            report_mismatch($sformatf("result %0d: found %b, expected %b",
                                      n_results, found, want.found));
          if (saturated !== want.sat)
            report_mismatch($sformatf("result %0d: saturated %b, expected %b",
                                      n_results, saturated, want.sat));
        end
      end
      if (cfg_valid && cfg_ready) knots_cfg = cfg_data;
      if (in_valid && in_ready) begin
        n_accepted++;
        if (req_type == REQ_LOAD) begin
          knot_tbl[knot_index] = knot_pos;
          a_tbl[knot_index]    = coef_const;
          b_tbl[knot_index]    = coef_lin;
          c_tbl[knot_index]    = coef_quad;
          d_tbl[knot_index]    = coef_cube;
        end else begin
          spline_q.push_back(spline_at(query_x));
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  // everything taken, every result back, then let in-flight loads settle
  task automatic drain();
    while (n_accepted != n_pushed || spline_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_knots(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int knots, input int s_idle, input int r_stall,
                           input int n_rand, input bit squeeze);
    int m;
    int r;
    int k;
    bit need;
    drain();
    write_knots(CFG_W'(knots));
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    m    = (knots > TBL_DEPTH) ? TBL_DEPTH : knots;
    need = 1'b0;
    for (int i = 0; i < m; i++) if (!gen_loaded[i]) need = 1'b1;
    if (need || (m > 0 && m <= 64)) build_table(m);
    // receiver holds off while the sender keeps offering items
    if (squeeze) hold_req++;
    repeat (n_rand) begin
      r = $urandom_range(99);
      if (r < 75) begin
        mk_eval(next_query(m));
      end else if (r < 90 && m > 0) begin
        // new coefficients, knot kept in place
        k = $urandom_range(m - 1);
        mk_load(IDX_W'(k), gen_pos[k], rand_coef(24), rand_coef(20), rand_coef(18),
                rand_coef(16));
      end else begin
        // stray load anywhere, may break the knot order
        mk_load(IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < TBL_DEPTH; i++) begin
      gen_pos[i]    = '0;
      gen_loaded[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, two knots at reset: full-range interval, dx clipping
    mk_load(0, Q_MIN32, ONE_Q, ONE_Q, '0, '0);
    mk_load(1, Q_MAX32, -1, -1, -1, -1);
    mk_eval(Q_MIN32);
    mk_eval(Q_MAX32);
    mk_eval('0);
    mk_eval(Q_MIN32 + 5);
    // positive clipping, below first knot, on and past the last knot
    mk_load(0, '0, Q_MAX32, Q_MAX32, Q_MAX32, Q_MAX32);
    mk_load(1, ONE_Q, Q_MIN32, Q_MIN32, Q_MIN32, Q_MIN32);
    mk_eval(-ONE_Q);
    mk_eval(ONE_Q);
    mk_eval(ONE_Q + 1);
    mk_eval('0);
    mk_eval(1);
    // negative clipping
    mk_load(0, '0, Q_MIN32, Q_MIN32, Q_MIN32, Q_MIN32);
    mk_eval(ONE_Q >>> 1);
    // rounding ties: linear term of one LSB
    mk_load(0, '0, '0, 1, '0, '0);
    mk_eval(32'sd32768);
    mk_eval(-32'sd32768);
    mk_eval(-32'sd98304);
    mk_eval(Q_MAX32);
    mk_eval(Q_MIN32);

    // random phases: knot count, sender idle %, receiver stall %, items
    run_phase(0, 0, 0, 40, 1'b0);
    run_phase(1, 82, 0, 40, 1'b0);
    run_phase(8, 0, 0, 120, 1'b0);
    run_phase(8, 0, 0, 120, 1'b1);
    run_phase(2, 82, 0, 150, 1'b0);
    run_phase(33, 0, 82, 150, 1'b0);
    run_phase(256, 20, 20, 40, 1'b0);
    run_phase(300, 0, 0, 30, 1'b0);
    run_phase(511, 0, 82, 30, 1'b0);
    run_phase(5, 82, 0, 150, 1'b0);
    run_phase(16, 0, 82, 150, 1'b0);
    run_phase(3 + $urandom_range(61), 20, 20, 150, 1'b0);
    run_phase(3, 0, 0, 60, 1'b0);

    drain();
    if (n_errors == 0) begin
      $display("piecewise_cubic_spline_eval_tb passed");
    end else begin
      $display("piecewise_cubic_spline_eval_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("piecewise_cubic_spline_eval_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/pcse_pkg.sv
design/pcse_ram.sv
design/pcse_mac.sv
design/piecewise_cubic_spline_eval.sv
sim/piecewise_cubic_spline_eval_tb.sv
